@@ rtl/jdbq_pkg.sv @@
package jdbq_pkg;

  localparam int SampleBitsDefault = 12;
  localparam int CenterBits        = 12;
  localparam int DeadZoneBits      = 12;
  localparam int DebounceBits      = 16;
  localparam int TimeBits          = 32;
  localparam int EntropyBits       = 32;
  localparam int RatioNum          = 13;
  localparam int RatioDen          = 10;

  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 16;

  localparam logic [CfgIndexBits-1:0] REG_CENTER_X      = 3'd0;
  localparam logic [CfgIndexBits-1:0] REG_CENTER_Y      = 3'd1;
  localparam logic [CfgIndexBits-1:0] REG_DEAD_ZONE     = 3'd2;
  localparam logic [CfgIndexBits-1:0] REG_DEBOUNCE_TIME = 3'd3;
  localparam logic [CfgIndexBits-1:0] REG_FLIP_X        = 3'd4;
  localparam logic [CfgIndexBits-1:0] REG_FLIP_Y        = 3'd5;
  localparam logic [CfgIndexBits-1:0] REG_PRESSED_LEVEL = 3'd6;

  localparam logic [CenterBits-1:0]   CenterReset   = 12'd2048;
  localparam logic [DeadZoneBits-1:0] DeadZoneReset = 12'd400;
  localparam logic [DebounceBits-1:0] DebounceReset = 16'd20;

  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_SELECT    = 2'd1;
  localparam logic [1:0] KIND_DIRECTION = 2'd2;

  localparam logic [1:0] MOVE_UP    = 2'd0;
  localparam logic [1:0] MOVE_DOWN  = 2'd1;
  localparam logic [1:0] MOVE_LEFT  = 2'd2;
  localparam logic [1:0] MOVE_RIGHT = 2'd3;

  localparam int OutDataBits = ((2 + EntropyBits + 7) / 8) * 8;

endpackage

@@ rtl/joystick_direction_and_button_qualifier.sv @@
// Joystick direction and button qualifier.
//
// Each input word on the s_axis channel is one poll: an x and a y sample, the
// raw button level and a millisecond timestamp. Each poll gives exactly one
// result word on the m_axis channel: the event kind in tuser, the direction
// and the new entropy register value in tdata.
// Configuration registers are written through the cfg channel, which is always
// ready; writes are to be made only while no poll is in flight.
// A poll is taken into an input register, classified by a single pass of
// compare and constant-multiply logic, and written to the result register
// together with the debounce and entropy state. The result word is valid once
// the poll has passed the input register and then the result register, and
// one poll per cycle is sustained unless the receiver stalls; the button
// state update in that single pass is what carries from one poll to the next.
// Reset clears both pipeline stages, loads the register reset values and
// sets the button history to the released level with a time stamp of zero.
// When the receiver stalls, the result word holds and the input register
// still takes one further poll; input ready then falls until the result is
// taken.
module joystick_direction_and_button_qualifier #(
  parameter int SAMPLE_BITS = jdbq_pkg::SampleBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample_x, sample_y, button_raw, now_ms, zero fill
  input  logic [((2*SAMPLE_BITS+jdbq_pkg::TimeBits+1+7)/8)*8-1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // direction, entropy, zero fill
  output logic [jdbq_pkg::OutDataBits-1:0]    m_axis_tdata,
  // event_kind
  output logic [1:0]                          m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [jdbq_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [jdbq_pkg::CfgDataBits-1:0]    cfg_data_i
);

  localparam int TW = jdbq_pkg::TimeBits;
  localparam int EW = jdbq_pkg::EntropyBits;
  localparam int MW = (SAMPLE_BITS > jdbq_pkg::CenterBits) ? SAMPLE_BITS
                                                           : jdbq_pkg::CenterBits;
  localparam int PW = MW + 4;
  localparam int InBits = 2 * SAMPLE_BITS + 1 + TW;
  localparam int InDataBits = ((InBits + 7) / 8) * 8;

  // Configuration registers
  logic [jdbq_pkg::CenterBits-1:0]   center_x_q, center_y_q;
  logic [jdbq_pkg::DeadZoneBits-1:0] dead_zone_q;
  logic [jdbq_pkg::DebounceBits-1:0] debounce_time_q;
  logic                              flip_x_q, flip_y_q, pressed_level_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q      <= jdbq_pkg::CenterReset;
      center_y_q      <= jdbq_pkg::CenterReset;
      dead_zone_q     <= jdbq_pkg::DeadZoneReset;
      debounce_time_q <= jdbq_pkg::DebounceReset;
      flip_x_q        <= 1'b0;
      flip_y_q        <= 1'b1;
      pressed_level_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        jdbq_pkg::REG_CENTER_X:      center_x_q      <= cfg_data_i[jdbq_pkg::CenterBits-1:0];
        jdbq_pkg::REG_CENTER_Y:      center_y_q      <= cfg_data_i[jdbq_pkg::CenterBits-1:0];
        jdbq_pkg::REG_DEAD_ZONE:     dead_zone_q     <= cfg_data_i[jdbq_pkg::DeadZoneBits-1:0];
        jdbq_pkg::REG_DEBOUNCE_TIME: debounce_time_q <= cfg_data_i;
        jdbq_pkg::REG_FLIP_X:        flip_x_q        <= cfg_data_i[0];
        jdbq_pkg::REG_FLIP_Y:        flip_y_q        <= cfg_data_i[0];
        jdbq_pkg::REG_PRESSED_LEVEL: pressed_level_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Handshake and pipeline control
  logic in_v_q, out_v_q;
  logic advance;

  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;
  assign m_axis_tvalid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Input register
  logic [SAMPLE_BITS-1:0] sx_q, sy_q;
  logic                   level_q;
  logic [TW-1:0]          now_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sx_q    <= s_axis_tdata[SAMPLE_BITS-1:0];
      sy_q    <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      level_q <= s_axis_tdata[2*SAMPLE_BITS];
      now_q   <= s_axis_tdata[InBits-1:2*SAMPLE_BITS+1];
    end
  end

  // Button and entropy state
  logic          last_level_q, last_level_d;
  logic          stable_pressed_q, stable_pressed_d;
  logic [TW-1:0] change_time_q, change_time_d;
  logic [EW-1:0] entropy_q, entropy_d;
  logic [TW-1:0] elapsed;
  logic          pressed, select_edge;

  always_comb begin
    last_level_d     = last_level_q;
    stable_pressed_d = stable_pressed_q;
    change_time_d    = change_time_q;
    select_edge      = 1'b0;
    elapsed          = now_q - change_time_q;
    pressed          = (level_q == pressed_level_q);
    if (level_q != last_level_q) begin
      last_level_d  = level_q;
      change_time_d = now_q;
    end else if (elapsed >= TW'(debounce_time_q)) begin
      select_edge      = pressed && !stable_pressed_q;
      stable_pressed_d = pressed;
    end
    entropy_d = {entropy_q[EW-2:0], sx_q[0] ^ sy_q[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q     <= 1'b1;
      stable_pressed_q <= 1'b0;
      change_time_q    <= '0;
      entropy_q        <= '0;
    end else if (advance) begin
      last_level_q     <= last_level_d;
      stable_pressed_q <= stable_pressed_d;
      change_time_q    <= change_time_d;
      entropy_q        <= entropy_d;
    end
  end

  // Direction classification
  logic signed [MW:0] dx, dy, ndx, ndy;
  logic [MW-1:0]      ax, ay, dz;
  logic [PW-1:0]      ax_den, ay_den, ax_num, ay_num;
  logic               x_pos, y_pos, x_dom, y_dom, both_inside;
  logic [1:0]         kind_d, dir_d;

  always_comb begin
    dx     = $signed({1'b0, MW'(sx_q)}) - $signed({1'b0, MW'(center_x_q)});
    dy     = $signed({1'b0, MW'(sy_q)}) - $signed({1'b0, MW'(center_y_q)});
    ndx    = -dx;
    ndy    = -dy;
    ax     = dx[MW] ? ndx[MW-1:0] : dx[MW-1:0];
    ay     = dy[MW] ? ndy[MW-1:0] : dy[MW-1:0];
    dz     = MW'(dead_zone_q);
    ax_den = PW'(ax) * PW'(jdbq_pkg::RatioDen);
    ay_den = PW'(ay) * PW'(jdbq_pkg::RatioDen);
    ax_num = PW'(ax) * PW'(jdbq_pkg::RatioNum);
    ay_num = PW'(ay) * PW'(jdbq_pkg::RatioNum);
    x_pos  = !dx[MW] && (dx != '0);
    y_pos  = !dy[MW] && (dy != '0);
    x_dom  = ax_den >= ay_num;
    y_dom  = ay_den >= ax_num;
    both_inside = (ax < dz) && (ay < dz);

    kind_d = jdbq_pkg::KIND_NONE;
    dir_d  = jdbq_pkg::MOVE_UP;
    if (select_edge) begin
      kind_d = jdbq_pkg::KIND_SELECT;
    end else if (!both_inside) begin
      if (x_dom) begin
        if (ax >= dz) begin
          kind_d = jdbq_pkg::KIND_DIRECTION;
          dir_d  = (x_pos ^ flip_x_q) ? jdbq_pkg::MOVE_RIGHT : jdbq_pkg::MOVE_LEFT;
        end
      end else if (y_dom) begin
        if (ay >= dz) begin
          kind_d = jdbq_pkg::KIND_DIRECTION;
          dir_d  = (y_pos ^ flip_y_q) ? jdbq_pkg::MOVE_UP : jdbq_pkg::MOVE_DOWN;
        end
      end
    end
  end

  // Result register
  logic [1:0]    kind_q, dir_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q <= kind_d;
      dir_q  <= dir_d;
    end
  end

  assign m_axis_tuser = kind_q;
  assign m_axis_tdata = jdbq_pkg::OutDataBits'({entropy_q, dir_q});

  // Assertions
  a_dir_up_without_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != jdbq_pkg::KIND_DIRECTION)) |->
      (m_axis_tdata[1:0] == jdbq_pkg::MOVE_UP))
    else $error("direction not up on a non-direction result");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("result register not valid after a pipeline advance");

  a_entropy_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (entropy_q[EW-1:1] == $past(entropy_q[EW-2:0])))
    else $error("entropy register did not shift by one");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_v_q && m_axis_tvalid && !m_axis_tready))
    else $error("input ready low without a stalled full pipeline");

  a_unused_input_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> (InDataBits >= InBits))
    else $error("input data word narrower than its fields");

endmodule

@@ tb/joystick_direction_and_button_qualifier_tb.sv @@
`timescale 1ns / 100ps

module joystick_direction_and_button_qualifier_tb;
  import jdbq_pkg::*;

  localparam int SB         = SampleBitsDefault;
  localparam int InBits     = ((2 * SB + TimeBits + 1 + 7) / 8) * 8;
  localparam int PollBits   = 2 * SB + 1 + TimeBits;
  localparam int SampleMax  = (1 << SB) - 1;
  localparam int HoldCycles = 250;
  localparam int PhaseItems = 150;

  localparam logic [CfgIndexBits-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic [TimeBits-1:0] now_ms;
    logic                button_raw;
    logic [SB-1:0]       sample_y;
    logic [SB-1:0]       sample_x;
  } poll_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [1:0]             dir;
    logic [EntropyBits-1:0] entropy;
  } qual_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InBits-1:0]       s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataBits-1:0]  m_axis_tdata;
  logic [1:0]              m_axis_tuser;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIndexBits-1:0] cfg_index_i   = '0;
  logic [CfgDataBits-1:0]  cfg_data_i    = '0;

  logic [CenterBits-1:0]   ctr_x        = CenterReset;
  logic [CenterBits-1:0]   ctr_y        = CenterReset;
  logic [DeadZoneBits-1:0] dz_lim       = DeadZoneReset;
  logic [DebounceBits-1:0] hold_lim     = DebounceReset;
  logic                    flip_x_en    = 1'b0;
  logic                    flip_y_en    = 1'b1;
  logic                    pressed_lvl  = 1'b0;

  logic                    last_level     = 1'b1;
  logic                    stable_pressed = 1'b0;
  logic [TimeBits-1:0]     change_ms      = '0;
  logic [EntropyBits-1:0]  entropy_sr     = '0;

  poll_t poll_q[$];
  qual_t qualified_q[$];

  logic [TimeBits-1:0] clock_ms = 32'd100;
  int gap_left     = 0;
  int burst_left   = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;
  int stall_mode   = 0;
  int mode_left    = 0;
  logic [31:0] stall_bits = '0;

  int n_polls     = 0;
  int n_results   = 0;
  int n_select    = 0;
  int n_direction = 0;
  int n_quiet     = 0;
  int n_writes    = 0;
  int n_fail      = 0;

  joystick_direction_and_button_qualifier u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic qualify_poll(input poll_t p);
    logic [TimeBits-1:0] held_for;
    logic is_pressed;
    logic press_edge;
    int dx, dy, ax, ay, dzi;
    qual_t q;
    press_edge = 1'b0;
    entropy_sr = {entropy_sr[EntropyBits-2:0], p.sample_x[0] ^ p.sample_y[0]};
    if (p.button_raw != last_level) begin
      last_level = p.button_raw;
      change_ms  = p.now_ms;
    end else begin
      held_for = p.now_ms - change_ms;
      if (held_for >= TimeBits'(hold_lim)) begin
        is_pressed     = (p.button_raw == pressed_lvl);
        press_edge     = is_pressed && !stable_pressed;
        stable_pressed = is_pressed;
      end
    end
    q.kind    = KIND_NONE;
    q.dir     = MOVE_UP;
    q.entropy = entropy_sr;
    if (press_edge) begin
      q.kind = KIND_SELECT;
    end else begin
      dx  = int'(p.sample_x) - int'(ctr_x);
      dy  = int'(p.sample_y) - int'(ctr_y);
      ax  = (dx < 0) ? -dx : dx;
      ay  = (dy < 0) ? -dy : dy;
      dzi = int'(dz_lim);
      if (!(ax < dzi && ay < dzi)) begin
        if (ax * RatioDen >= ay * RatioNum) begin
          if (ax >= dzi) begin
            q.kind = KIND_DIRECTION;
            if (flip_x_en) q.dir = (dx > 0) ? MOVE_LEFT : MOVE_RIGHT;
            else q.dir = (dx > 0) ? MOVE_RIGHT : MOVE_LEFT;
          end
        end else if (ay * RatioDen >= ax * RatioNum) begin
          if (ay >= dzi) begin
            q.kind = KIND_DIRECTION;
            if (flip_y_en) q.dir = (dy > 0) ? MOVE_DOWN : MOVE_UP;
            else q.dir = (dy > 0) ? MOVE_UP : MOVE_DOWN;
          end
        end
      end
    end
    case (q.kind)
      KIND_SELECT:    n_select++;
      KIND_DIRECTION: n_direction++;
      default:        n_quiet++;
    endcase
    n_polls++;
    qualified_q.push_back(q);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        qualify_poll(poll_t'(s_axis_tdata[PollBits-1:0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (poll_q.size() > 0) begin
          s_axis_tdata  <= InBits'(poll_q.pop_front());
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 64);
        stall_bits = $urandom;
      end
      mode_left--;
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= stall_bits[mode_left % 32];
      endcase
    end
  end

  always @(posedge clk_i) begin
    qual_t got;
    qual_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind    = m_axis_tuser;
      got.dir     = m_axis_tdata[1:0];
      got.entropy = m_axis_tdata[2 +: EntropyBits];
      n_results++;
      if (qualified_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) begin
          $display("Unexpected result word: kind %0d dir %0d entropy %h",
                   got.kind, got.dir, got.entropy);
        end
      end else begin
        want = qualified_q.pop_front();
        if (got.kind !== want.kind || got.dir !== want.dir ||
            got.entropy !== want.entropy) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("Mismatch on word %0d: expected kind %0d dir %0d entropy %h, %s",
                     n_results, want.kind, want.dir, want.entropy,
                     $sformatf("got kind %0d dir %0d entropy %h",
                               got.kind, got.dir, got.entropy));
          end
        end
      end
    end
  end

  task automatic push_poll(input int x, input int y, input logic b, input logic [31:0] t);
    poll_t p;
    p.sample_x   = SB'(x);
    p.sample_y   = SB'(y);
    p.button_raw = b;
    p.now_ms     = t;
    poll_q.push_back(p);
  endtask

  task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
                           input logic [CfgDataBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_writes++;
    case (idx)
      REG_CENTER_X:      ctr_x       = val[CenterBits-1:0];
      REG_CENTER_Y:      ctr_y       = val[CenterBits-1:0];
      REG_DEAD_ZONE:     dz_lim      = val[DeadZoneBits-1:0];
      REG_DEBOUNCE_TIME: hold_lim    = val[DebounceBits-1:0];
      REG_FLIP_X:        flip_x_en   = val[0];
      REG_FLIP_Y:        flip_y_en   = val[0];
      REG_PRESSED_LEVEL: pressed_lvl = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int cx, input int cy, input int dz, input int deb,
                                input int fx, input int fy, input int pl);
    write_reg(REG_CENTER_X, {4'($urandom), 12'(cx)});
    write_reg(REG_CENTER_Y, {4'($urandom), 12'(cy)});
    write_reg(REG_DEAD_ZONE, {4'($urandom), 12'(dz)});
    write_reg(REG_DEBOUNCE_TIME, 16'(deb));
    write_reg(REG_FLIP_X, {15'($urandom), 1'(fx)});
    write_reg(REG_FLIP_Y, {15'($urandom), 1'(fy)});
    write_reg(REG_PRESSED_LEVEL, {15'($urandom), 1'(pl)});
    write_reg(RegUnused, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_settings();
    int cx, cy, deb;
    cx  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SampleMax) : $urandom_range(1648, 2448);
    cy  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SampleMax) : $urandom_range(1648, 2448);
    deb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 60);
    apply_settings(cx, cy, $urandom_range(0, 900), deb, $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  function automatic int clampv(input int v);
    return (v < 0) ? 0 : (v > SampleMax) ? SampleMax : v;
  endfunction

  function automatic int spread(input int centre, input int span);
    return clampv(centre + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic int pick_extreme(input int centre);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return SampleMax;
      default: return centre;
    endcase
  endfunction

  task automatic random_polls(input int n);
    int run_left, bounce, step_max, reach, along, across, x, y, tmp;
    logic lvl, b;
    run_left = 0;
    bounce   = 0;
    lvl      = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      reach = $urandom_range(300, 2047);
      case ($urandom_range(0, 3))
        0: begin
          x = $urandom_range(0, SampleMax);
          y = $urandom_range(0, SampleMax);
        end
        1: begin
          along  = $urandom_range(0, 1) ? reach : -reach;
          across = int'($urandom_range(0, reach)) - reach / 2;
          x = clampv(int'(ctr_x) + along);
          y = clampv(int'(ctr_y) + across);
          if ($urandom_range(0, 1)) begin
            x   = clampv(int'(ctr_x) + across);
            y   = clampv(int'(ctr_y) + along);
          end
        end
        2: begin
          x = spread(int'(ctr_x), int'(dz_lim) + 64);
          y = spread(int'(ctr_y), int'(dz_lim) + 64);
        end
        default: begin
          x = pick_extreme(int'(ctr_x));
          y = pick_extreme(int'(ctr_y));
        end
      endcase
      if ($urandom_range(0, 99) < 12) begin
        push_poll(x, y, 1'($urandom_range(0, 1)), $urandom);
      end else begin
        if (run_left == 0) begin
          lvl      = ~lvl;
          run_left = $urandom_range(2, 12);
          bounce   = $urandom_range(0, 3);
        end
        b = lvl;
        if (bounce > 0 && $urandom_range(0, 1)) begin
          b = ~lvl;
          bounce--;
        end
        run_left--;
        step_max = int'(hold_lim) / 3 + 3;
        if ($urandom_range(0, 9) == 0) step_max = 2 * int'(hold_lim) + 10;
        tmp      = $urandom_range(0, step_max);
        clock_ms = clock_ms + 32'(tmp);
        push_poll(x, y, b, clock_ms);
      end
    end
  endtask

  task automatic wait_idle();
    while (poll_q.size() != 0 || s_axis_tvalid || qualified_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: every direction, ratio and dead-zone boundaries, debounce and wrap.
    push_poll(0, 2048, 1'b1, 32'd100);
    push_poll(4095, 2048, 1'b1, 32'd105);
    push_poll(2048, 0, 1'b1, 32'd110);
    push_poll(2048, 4095, 1'b1, 32'd115);
    push_poll(2048, 2048, 1'b1, 32'd120);
    push_poll(3348, 3048, 1'b1, 32'd125);
    push_poll(3347, 3048, 1'b1, 32'd130);
    push_poll(2448, 2048, 1'b1, 32'd135);
    push_poll(2447, 2048, 1'b1, 32'd140);
    push_poll(4095, 4095, 1'b0, 32'd150);
    push_poll(0, 4095, 1'b0, 32'd160);
    push_poll(2048, 2048, 1'b0, 32'd171);
    push_poll(0, 2048, 1'b0, 32'd180);
    push_poll(2048, 4095, 1'b1, 32'd190);
    push_poll(2048, 2048, 1'b1, 32'd215);
    push_poll(2048, 2048, 1'b0, 32'hFFFF_FFF0);
    push_poll(2048, 2048, 1'b0, 32'h0000_000C);
    push_poll(1, 2, 1'b1, 32'hFFFF_FFFF);
    push_poll(4095, 0, 1'b1, 32'h0000_0000);
    wait_idle();

    // Zero dead zone and zero debounce time, with the first samples on the centres.
    apply_settings(4095, 0, 0, 0, 1, 0, 1);
    push_poll(4095, 0, 1'b1, 32'd1);
    push_poll(4095, 0, 1'b0, 32'd2);
    push_poll(4095, 0, 1'b0, 32'd2);
    push_poll(4095, 0, 1'b1, 32'd3);
    push_poll(4095, 0, 1'b1, 32'd3);
    push_poll(0, 0, 1'b1, 32'd4);
    push_poll(4095, 4095, 1'b1, 32'd5);
    clock_ms = 32'd5;
    random_polls(PhaseItems);
    wait_idle();

    apply_settings(0, 4095, 4095, 65535, 0, 1, 0);
    random_polls(PhaseItems);

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      random_settings();
      if (ph == 2) holds_asked++;
      if (ph == 4) clock_ms = 32'hFFFF_FF00;
      random_polls(PhaseItems);
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    n_fail += qualified_q.size();

    $display("Covered %0d polls over %0d register writes: %0d select, %0d direction, %0d quiet.",
             n_polls, n_writes, n_select, n_direction, n_quiet);
    $display("Checked %0d result words, %0d failures.", n_results, n_fail);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
